// ===== sv/pip3d_pkg.sv =====
// Shared types and constants for the 3D point-in-polygon crossing test.
package pip3d_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    typedef enum logic [1:0] {
        AXIS_DROP_X = 2'd0,
        AXIS_DROP_Y = 2'd1,
        AXIS_DROP_Z = 2'd2
    } t_axis;

endpackage

// ===== sv/pip3d_axis_sel.sv =====
// Dropped-axis choice from the largest normal magnitude, ties to x then y.
module pip3d_axis_sel #(
    parameter int COORD_WIDTH = pip3d_pkg::COORD_WIDTH_DEF
) (
    input  logic signed [COORD_WIDTH-1:0] i_normal_x,
    input  logic signed [COORD_WIDTH-1:0] i_normal_y,
    input  logic signed [COORD_WIDTH-1:0] i_normal_z,
    output pip3d_pkg::t_axis              o_axis
);
    import pip3d_pkg::*;

    logic [COORD_WIDTH-1:0] mag_x;
    logic [COORD_WIDTH-1:0] mag_y;
    logic [COORD_WIDTH-1:0] mag_z;

    assign mag_x = i_normal_x[COORD_WIDTH-1] ? (~i_normal_x + 1'b1) : i_normal_x;
    assign mag_y = i_normal_y[COORD_WIDTH-1] ? (~i_normal_y + 1'b1) : i_normal_y;
    assign mag_z = i_normal_z[COORD_WIDTH-1] ? (~i_normal_z + 1'b1) : i_normal_z;

    always_comb begin
        if (mag_x >= mag_y && mag_x >= mag_z) begin
            o_axis = AXIS_DROP_X;
        end else if (mag_y >= mag_x && mag_y >= mag_z) begin
            o_axis = AXIS_DROP_Y;
        end else begin
            o_axis = AXIS_DROP_Z;
        end
    end

endmodule

// ===== sv/pip3d_edge_test.sv =====
// Edge straddle and ray crossing test for one polygon edge.
module pip3d_edge_test #(
    parameter int COORD_WIDTH = pip3d_pkg::COORD_WIDTH_DEF
) (
    input  logic signed [COORD_WIDTH-1:0] i_pu,
    input  logic signed [COORD_WIDTH-1:0] i_pv,
    input  logic signed [COORD_WIDTH-1:0] i_cu,
    input  logic signed [COORD_WIDTH-1:0] i_cv,
    input  logic signed [COORD_WIDTH-1:0] i_tu,
    input  logic signed [COORD_WIDTH-1:0] i_tv,
    output logic                          o_toggle
);
    localparam int D_W = COORD_WIDTH + 1;
    localparam int P_W = 2 * D_W;

    logic              above_p;
    logic              above_c;
    logic signed [D_W-1:0] d_a;
    logic signed [D_W-1:0] d_b;
    logic signed [D_W-1:0] d_c;
    logic signed [D_W-1:0] d_d;
    logic signed [P_W-1:0] p_ab;
    logic signed [P_W-1:0] p_cd;

    assign above_p = i_pv >= i_tv;
    assign above_c = i_cv >= i_tv;

    assign d_a = D_W'(i_cv) - D_W'(i_tv);
    assign d_b = D_W'(i_pu) - D_W'(i_cu);
    assign d_c = D_W'(i_cu) - D_W'(i_tu);
    assign d_d = D_W'(i_pv) - D_W'(i_cv);

    assign p_ab = P_W'(d_a) * P_W'(d_b);
    assign p_cd = P_W'(d_c) * P_W'(d_d);

    assign o_toggle = (above_p != above_c) && ((p_ab >= p_cd) == above_c);

endmodule

// ===== sv/point_in_polygon_3d_crossing_top.sv =====
// Top level of the streaming 3D point-in-polygon crossing test.
//
// Input channel: one polygon vertex per transfer (i_in_valid / o_in_stall).
// The first vertex of a polygon also carries the test point and the normal;
// the normal picks the projection axis to drop, and both are held for the
// rest of the polygon. i_last_vertex marks the final vertex.
// Output channel: one transfer (o_out_valid / i_out_stall) per polygon,
// o_inside_res = 1 when the point lies inside.
// Throughput: one vertex per cycle, unless a last vertex waits on a stalled output.
// Between the input register and the result register each vertex goes through
// projection, two parallel edge tests (two multiplies each) and the parity update
// in combinational logic; o_out_valid is driven from the result register.
// While the output is stalled with a result pending, vertices that carry no
// result keep flowing; a last vertex waits in the input register.
// Reset: synchronous, active low; empties both registers and starts a new
// polygon with the next vertex.
module point_in_polygon_3d_crossing_top #(
    parameter int COORD_WIDTH = pip3d_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_z,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    input  logic signed [COORD_WIDTH-1:0] i_normal_x,
    input  logic signed [COORD_WIDTH-1:0] i_normal_y,
    input  logic signed [COORD_WIDTH-1:0] i_normal_z,
    input  logic                          i_last_vertex,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_inside_res
);
    import pip3d_pkg::*;

    logic                          r_in_valid;
    logic signed [COORD_WIDTH-1:0] r_vx;
    logic signed [COORD_WIDTH-1:0] r_vy;
    logic signed [COORD_WIDTH-1:0] r_vz;
    logic signed [COORD_WIDTH-1:0] r_px;
    logic signed [COORD_WIDTH-1:0] r_py;
    logic signed [COORD_WIDTH-1:0] r_pz;
    logic signed [COORD_WIDTH-1:0] r_nx;
    logic signed [COORD_WIDTH-1:0] r_ny;
    logic signed [COORD_WIDTH-1:0] r_nz;
    logic                          r_last;

    logic                          r_mid;
    t_axis                         r_axis;
    logic signed [COORD_WIDTH-1:0] r_test_u;
    logic signed [COORD_WIDTH-1:0] r_test_v;
    logic signed [COORD_WIDTH-1:0] r_first_u;
    logic signed [COORD_WIDTH-1:0] r_first_v;
    logic signed [COORD_WIDTH-1:0] r_prev_u;
    logic signed [COORD_WIDTH-1:0] r_prev_v;
    logic                          r_parity;

    logic                          r_out_valid;
    logic                          r_out_res;

    logic                          out_free;
    logic                          consume;
    logic                          in_take;
    t_axis                         sel_axis;
    t_axis                         cur_axis;
    logic signed [COORD_WIDTH-1:0] cur_u;
    logic signed [COORD_WIDTH-1:0] cur_v;
    logic signed [COORD_WIDTH-1:0] pnt_u;
    logic signed [COORD_WIDTH-1:0] pnt_v;
    logic signed [COORD_WIDTH-1:0] tst_u;
    logic signed [COORD_WIDTH-1:0] tst_v;
    logic signed [COORD_WIDTH-1:0] fst_u;
    logic signed [COORD_WIDTH-1:0] fst_v;
    logic                          tog_open;
    logic                          tog_close;
    logic                          par_open;
    logic                          par_close;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign consume    = r_in_valid && (!r_last || out_free);
    assign o_in_stall = r_in_valid && !consume;
    assign in_take    = i_in_valid && !o_in_stall;

    pip3d_axis_sel #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_axis_sel (
        .i_normal_x (r_nx),
        .i_normal_y (r_ny),
        .i_normal_z (r_nz),
        .o_axis     (sel_axis)
    );

    assign cur_axis = r_mid ? r_axis : sel_axis;

    always_comb begin
        unique case (cur_axis)
            AXIS_DROP_X: begin
                cur_u = r_vy;
                cur_v = r_vz;
                pnt_u = r_py;
                pnt_v = r_pz;
            end
            AXIS_DROP_Y: begin
                cur_u = r_vx;
                cur_v = r_vz;
                pnt_u = r_px;
                pnt_v = r_pz;
            end
            default: begin
                cur_u = r_vx;
                cur_v = r_vy;
                pnt_u = r_px;
                pnt_v = r_py;
            end
        endcase
    end

    assign tst_u = r_mid ? r_test_u  : pnt_u;
    assign tst_v = r_mid ? r_test_v  : pnt_v;
    assign fst_u = r_mid ? r_first_u : cur_u;
    assign fst_v = r_mid ? r_first_v : cur_v;

    pip3d_edge_test #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_edge_open (
        .i_pu     (r_prev_u),
        .i_pv     (r_prev_v),
        .i_cu     (cur_u),
        .i_cv     (cur_v),
        .i_tu     (tst_u),
        .i_tv     (tst_v),
        .o_toggle (tog_open)
    );

    pip3d_edge_test #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_edge_close (
        .i_pu     (cur_u),
        .i_pv     (cur_v),
        .i_cu     (fst_u),
        .i_cv     (fst_v),
        .i_tu     (tst_u),
        .i_tv     (tst_v),
        .o_toggle (tog_close)
    );

    assign par_open  = r_mid && (r_parity ^ tog_open);
    assign par_close = par_open ^ (r_last && tog_close);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || consume) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_vx   <= i_vertex_x;
            r_vy   <= i_vertex_y;
            r_vz   <= i_vertex_z;
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_pz   <= i_point_z;
            r_nx   <= i_normal_x;
            r_ny   <= i_normal_y;
            r_nz   <= i_normal_z;
            r_last <= i_last_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid     <= 1'b0;
            r_axis    <= AXIS_DROP_X;
            r_test_u  <= '0;
            r_test_v  <= '0;
            r_first_u <= '0;
            r_first_v <= '0;
            r_prev_u  <= '0;
            r_prev_v  <= '0;
            r_parity  <= 1'b0;
        end else if (consume) begin
            r_mid     <= !r_last;
            r_axis    <= cur_axis;
            r_test_u  <= tst_u;
            r_test_v  <= tst_v;
            r_first_u <= fst_u;
            r_first_v <= fst_v;
            r_prev_u  <= cur_u;
            r_prev_v  <= cur_v;
            r_parity  <= par_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= consume && r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && consume && r_last) begin
            r_out_res <= par_close;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_res;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_last |=> o_out_valid)
        else $error("last vertex did not produce a result");

    a_last_ends_polygon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_last |=> !r_mid)
        else $error("polygon still open after last vertex");

    a_vertex_opens_polygon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && !r_last |=> r_mid)
        else $error("polygon not open after inner vertex");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_last && o_out_valid)
        else $error("input stalled without a blocked last vertex");

endmodule

// ===== verif/tb_point_in_polygon_3d_crossing_top.sv =====
// Testbench: streams 3D polygons through the crossing test and checks each inside flag.
`timescale 1ns / 100ps

module tb_point_in_polygon_3d_crossing_top;
    import pip3d_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;

    typedef logic signed [CW-1:0] t_coord;

    localparam t_coord C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord C_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct {
        t_coord vx, vy, vz;
        t_coord px, py, pz;
        t_coord nx, ny, nz;
        logic   last;
        bit     hold;
    } t_vertex;

    logic    i_clk     = 1'b0;
    logic    i_rst_n   = 1'b0;
    logic    in_valid  = 1'b0;
    logic    out_stall = 1'b0;
    t_vertex cur       = '{default: '0};
    logic    o_in_stall;
    logic    o_out_valid;
    logic    o_inside_res;

    t_vertex vertex_q[$];
    bit      inside_q[$];

    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 83;
    bit          in_taken      = 1'b0;
    int          err_cnt       = 0;
    int          n_vertices    = 0;
    int          n_polys       = 0;
    int          n_inside      = 0;

    t_axis  drop_ax = AXIS_DROP_X;
    longint tst_u   = 0;
    longint tst_v   = 0;
    longint fst_u   = 0;
    longint fst_v   = 0;
    longint prv_u   = 0;
    longint prv_v   = 0;
    bit     in_poly = 1'b0;
    bit     parity  = 1'b0;

    point_in_polygon_3d_crossing_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_vertex_x   (cur.vx),
        .i_vertex_y   (cur.vy),
        .i_vertex_z   (cur.vz),
        .i_point_x    (cur.px),
        .i_point_y    (cur.py),
        .i_point_z    (cur.pz),
        .i_normal_x   (cur.nx),
        .i_normal_y   (cur.ny),
        .i_normal_z   (cur.nz),
        .i_last_vertex(cur.last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_inside_res (o_inside_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint mag(t_coord c);
        return (c < 0) ? -longint'(c) : longint'(c);
    endfunction

    task automatic project(input t_coord x, input t_coord y, input t_coord z,
                           output longint u, output longint v);
        case (drop_ax)
            AXIS_DROP_X: begin
                u = y;
                v = z;
            end
            AXIS_DROP_Y: begin
                u = x;
                v = z;
            end
            default: begin
                u = x;
                v = y;
            end
        endcase
    endtask

    function automatic bit crosses(longint pu, longint pv, longint cu, longint cv);
        bit above_p;
        bit above_c;
        above_p = pv >= tst_v;
        above_c = cv >= tst_v;
        if (above_p == above_c) return 1'b0;
        return (((cv - tst_v) * (pu - cu)) >= ((cu - tst_u) * (pv - cv))) == above_c;
    endfunction

    task automatic track_vertex(input t_vertex it);
        longint cu, cv, ax, ay, az;
        if (!in_poly) begin
            ax = mag(it.nx);
            ay = mag(it.ny);
            az = mag(it.nz);
            if (ax >= ay && ax >= az) drop_ax = AXIS_DROP_X;
            else if (ay >= az) drop_ax = AXIS_DROP_Y;
            else drop_ax = AXIS_DROP_Z;
            project(it.px, it.py, it.pz, tst_u, tst_v);
            project(it.vx, it.vy, it.vz, cu, cv);
            fst_u = cu;
            fst_v = cv;
            parity = 1'b0;
        end else begin
            project(it.vx, it.vy, it.vz, cu, cv);
            if (crosses(prv_u, prv_v, cu, cv)) parity = !parity;
        end
        prv_u = cu;
        prv_v = cv;
        if (it.last) begin
            if (crosses(cu, cv, fst_u, fst_v)) parity = !parity;
            inside_q.push_back(parity);
            in_poly = 1'b0;
        end else begin
            in_poly = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (inside_q.size() == 0) begin
                $error("inside_res: unexpected transfer, actual %0d", o_inside_res);
                err_cnt++;
            end else begin
                want = inside_q.pop_front();
                n_polys++;
                if (want) n_inside++;
                if (o_inside_res !== want) begin
                    $error("inside_res mismatch: expected %0d, actual %0d", want, o_inside_res);
                    err_cnt++;
                end
            end
        end
        in_taken = i_rst_n && in_valid && !o_in_stall;
        if (in_taken) begin
            track_vertex(cur);
            n_vertices++;
        end
    end

    always @(negedge i_clk) begin
        t_vertex nxt;
        bit      drive;
        if (i_rst_n && (!in_valid || in_taken)) begin
            drive = 1'b0;
            if (vertex_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
                && !(vertex_q[0].hold && inside_q.size() != 0)) begin
                nxt = vertex_q.pop_front();
                drive = 1'b1;
                cur <= nxt;
            end
            in_valid <= drive;
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic queue_vertex(input t_coord vx, input t_coord vy, input t_coord vz,
                                input t_coord px, input t_coord py, input t_coord pz,
                                input t_coord nx, input t_coord ny, input t_coord nz,
                                input logic last);
        t_vertex v;
        v = '{vx, vy, vz, px, py, pz, nx, ny, nz, last, 1'b0};
        vertex_q.push_back(v);
    endtask

    function automatic t_coord near(t_coord c, int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return t_coord'($urandom);
        if (r == 1) return $urandom_range(0, 1) ? C_MAX : C_MIN;
        return c + t_coord'($urandom_range(0, 2 * span)) - t_coord'(span);
    endfunction

    function automatic t_coord flip(t_coord c);
        return $urandom_range(0, 1) ? -c : c;
    endfunction

    task automatic queue_polygon(input int nv, input bit hold);
        t_vertex     v;
        t_coord      ptx, pty, ptz, nmx, nmy, nmz, m;
        int unsigned span;
        span = 2 << (4 * $urandom_range(0, 5));
        ptx = t_coord'($urandom);
        pty = t_coord'($urandom);
        ptz = t_coord'($urandom);
        m = t_coord'($urandom);
        case ($urandom_range(0, 7))
            0: begin
                nmx = '0;
                nmy = '0;
                nmz = '0;
            end
            1: begin
                nmx = flip(m);
                nmy = flip(m);
                nmz = flip(m);
            end
            2: begin
                nmx = flip(m);
                nmy = flip(m);
                nmz = m >>> 1;
            end
            3: begin
                nmx = m >>> 1;
                nmy = flip(m);
                nmz = flip(m);
            end
            4: begin
                nmx = C_MIN;
                nmy = t_coord'($urandom);
                nmz = t_coord'($urandom);
            end
            default: begin
                nmx = t_coord'($urandom);
                nmy = t_coord'($urandom);
                nmz = t_coord'($urandom);
            end
        endcase
        for (int i = 0; i < nv; i++) begin
            v.vx = near(ptx, span);
            v.vy = near(pty, span);
            v.vz = near(ptz, span);
            if (i == 0) begin
                v.px = ptx;
                v.py = pty;
                v.pz = ptz;
                v.nx = nmx;
                v.ny = nmy;
                v.nz = nmz;
            end else begin
                v.px = t_coord'($urandom);
                v.py = t_coord'($urandom);
                v.pz = t_coord'($urandom);
                v.nx = t_coord'($urandom);
                v.ny = t_coord'($urandom);
                v.nz = t_coord'($urandom);
            end
            v.last = (i == nv - 1);
            v.hold = hold && (i == 0);
            vertex_q.push_back(v);
        end
    endtask

    task automatic queue_random(input int budget);
        int used;
        int nv;
        int r;
        used = 0;
        while (used < budget) begin
            r = $urandom_range(0, 19);
            nv = (r == 0) ? 1 : (r == 1) ? 2 : $urandom_range(3, 9);
            queue_polygon(nv, used == 0 || $urandom_range(0, 49) == 0);
            used += nv;
        end
    endtask

    task automatic drain_feed();
        while (vertex_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        queue_vertex(100, 200, 300, 100, 200, 300, 0, 0, 0, 1'b1);

        queue_vertex(0, 0, 5, 512, 512, 0, 0, 0, 256, 1'b0);
        queue_vertex(1024, 0, 5, C_MIN, C_MAX, 0, C_MAX, 0, 0, 1'b0);
        queue_vertex(1024, 1024, 5, C_MAX, C_MIN, 7, 0, C_MIN, 0, 1'b0);
        queue_vertex(0, 1024, 5, 0, 0, 0, 1, 1, 1, 1'b1);

        queue_vertex(0, 0, 5, 2048, 512, 0, 0, 3, -256, 1'b0);
        queue_vertex(1024, 0, 5, 512, 512, 0, 0, 0, 0, 1'b0);
        queue_vertex(1024, 1024, 5, 512, 512, 0, 0, 0, 0, 1'b0);
        queue_vertex(0, 1024, 5, 512, 512, 0, 0, 0, 0, 1'b1);

        queue_vertex(0, C_MIN, C_MIN, 0, 0, 0, C_MIN, 0, 0, 1'b0);
        queue_vertex(0, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, 0, 0, 0, 1'b0);
        queue_vertex(C_MAX, 0, C_MAX, C_MIN, C_MIN, C_MIN, 0, 0, 0, 1'b1);

        queue_vertex(9, 0, 0, C_MAX, 10, 10, 7, 7, 7, 1'b0);
        queue_vertex(9, 100, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        queue_vertex(9, 0, 100, 0, 0, 0, 0, 0, 0, 1'b1);

        queue_vertex(0, 50, 0, 10, C_MIN, 0, 1, -7, 7, 1'b0);
        queue_vertex(100, 50, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        queue_vertex(0, 50, 100, 0, 0, 0, 0, 0, 0, 1'b1);

        queue_vertex(5, 5, 5, 5, 5, 0, 0, 0, 1, 1'b0);
        queue_vertex(5, 5, 5, 5, 5, 0, 0, 0, 1, 1'b0);
        queue_vertex(5, 5, 5, 5, 5, 0, 0, 0, 1, 1'b1);

        queue_random(650);
        drain_feed();
        send_idle_pct = 83;
        recv_idle_pct = 35;
        queue_random(650);
        drain_feed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(650);
        drain_feed();
        while (in_valid || inside_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d vertices in %0d polygons, %0d inside and %0d outside,",
                 n_vertices, n_polys, n_inside, n_polys - n_inside);
        $display("under sender-heavy, receiver-heavy and back-to-back flow control.");
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
